### src/plqr_pkg.sv
// Shared types and constants for the polyline to quad ribbon core.
package plqr_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned WidthW = 24;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SumW   = CoordW + 2;
  localparam int unsigned QuotW  = WidthW;
  localparam int unsigned NumW   = 57;
  localparam int unsigned DenW   = 56;

  localparam logic [WidthW-1:0] WidthReset = 24'd65536;
  localparam logic [CoordW-1:0] SatMax     = 32'h7fff_ffff;
  localparam logic [CoordW-1:0] SatMin     = 32'h8000_0000;
  localparam logic [63:0]       RootBitTop = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ABS,
    ST_NORM,
    ST_SQR,
    ST_ROOT,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

### src/polyline_to_quad_ribbon_core.sv
// Polyline to quad ribbon core: turns polyline points into quad corner words.
//
// Each accepted point word closes a segment from the previously held point and
// yields four corner words (start minus, start plus, end plus, end minus); the
// first point of a polyline is only stored and gives no output, and a point
// with end_of_line set ends the polyline. All arithmetic runs on one small
// sequencer around a single 32x32 multiplier, in this order: the segment
// difference and its magnitudes, normalizing the magnitudes (one shift a
// cycle), the sum of squares, the integer square root (one result bit a
// cycle), the two offset divisions (multiply, prepare, 24 quotient bits
// each) and handing out the four corners. A zero-length segment goes from
// normalizing straight to the corners. A segment point keeps the core busy
// until its last corner is loaded, which an output stall delays; a first
// point is only stored and leaves the core idle. in_ready is high only
// while the sequencer is idle. Corners sit in an output register, so the last
// corner may still wait for out_ready while the next point is taken.
// ribbon_width is written directly through cfg_write_en / cfg_write_data and
// must only change while the core is idle; it resets to 1.0 (Q8.16).
module polyline_to_quad_ribbon_core
  import plqr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write_en,
  input  logic [WidthW-1:0]        cfg_write_data,
  // point input
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] point_x,
  input  logic signed [CoordW-1:0] point_y,
  input  logic signed [CoordW-1:0] point_z,
  input  logic                     end_of_line,
  // corner output
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CoordW-1:0] corner_x,
  output logic signed [CoordW-1:0] corner_y,
  output logic signed [CoordW-1:0] corner_z,
  output logic [1:0]               corner_index,
  output logic                     quad_done
);

  state_t state, state_next;

  logic [WidthW-1:0] ribbon_width;

  // held point of the current polyline and the point being worked on
  logic [CoordW-1:0] prev_x, prev_y, prev_z;
  logic              have_prev;
  logic [CoordW-1:0] cur_x, cur_y, cur_z;
  logic              cur_eol;

  // differences, then magnitudes, then normalized magnitudes
  logic [DiffW-1:0]  ax, ay, az;
  logic              dx_neg, dz_pos;

  logic [1:0]        step;
  logic [63:0]       prod_q;
  logic [63:0]       acc;
  logic [63:0]       root;
  logic [63:0]       root_bit;

  logic              sel;
  logic [NumW-1:0]   num;
  logic [DenW-1:0]   den;
  logic [QuotW-1:0]  quot;
  logic [4:0]        div_cnt;
  logic [QuotW-1:0]  mx, mz;

  logic [1:0]        emit_k;

  // shared multiplier
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;

  logic              in_take;
  logic              emit_load;
  logic              norm_zero, norm_right, norm_left;
  logic [63:0]       root_try;
  logic              root_ge;
  logic              div_ge;
  logic [QuotW-1:0]  quot_next;

  logic              plus_side;
  logic [CoordW-1:0] base_x, base_y, base_z;
  logic [SumW-1:0]   wide_x, wide_z, off_x, off_z, sum_x, sum_z;
  logic [CoordW-1:0] sat_x, sat_z;

  assign in_take   = in_valid && in_ready;
  assign emit_load = (state == ST_EMIT) && (!out_valid || out_ready);

  assign norm_zero  = (ax == '0) && (ay == '0) && (az == '0);
  assign norm_right = |{ax[DiffW-1:DiffW-2], ay[DiffW-1:DiffW-2], az[DiffW-1:DiffW-2]};
  assign norm_left  = ~|{ax[DiffW-1:DiffW-3], ay[DiffW-1:DiffW-3], az[DiffW-1:DiffW-3]};

  // multiplier operand select: squares first, then magnitude times width
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_SQR) begin
      case (step)
        2'd0:    mul_a = ax[31:0];
        2'd1:    mul_a = ay[31:0];
        default: mul_a = az[31:0];
      endcase
      mul_b = mul_a;
    end else begin
      mul_a = sel ? ax[31:0] : az[31:0];
      mul_b = {8'd0, ribbon_width};
    end
  end
  assign mul_p = mul_a * mul_b;

  // one digit of the square root
  assign root_try = root + root_bit;
  assign root_ge  = (acc >= root_try);

  // one quotient bit of the offset division
  assign div_ge    = (num >= {1'b0, den});
  assign quot_next = {quot[QuotW-2:0], div_ge};

  // corner arithmetic: pick the end, add or drop the offset, saturate
  assign plus_side = emit_k[0] ^ emit_k[1];
  assign base_x    = emit_k[1] ? cur_x : prev_x;
  assign base_y    = emit_k[1] ? cur_y : prev_y;
  assign base_z    = emit_k[1] ? cur_z : prev_z;
  assign wide_x    = {{2{base_x[CoordW-1]}}, base_x};
  assign wide_z    = {{2{base_z[CoordW-1]}}, base_z};
  assign off_x     = {{(SumW-QuotW){1'b0}}, mx};
  assign off_z     = {{(SumW-QuotW){1'b0}}, mz};
  assign sum_x     = (plus_side ^ dz_pos) ? wide_x + off_x : wide_x - off_x;
  assign sum_z     = (plus_side ^ dx_neg) ? wide_z + off_z : wide_z - off_z;

  always_comb begin
    if (sum_x[SumW-1:CoordW-1] == 3'b000 || sum_x[SumW-1:CoordW-1] == 3'b111) begin
      sat_x = sum_x[CoordW-1:0];
    end else begin
      sat_x = sum_x[SumW-1] ? SatMin : SatMax;
    end
    if (sum_z[SumW-1:CoordW-1] == 3'b000 || sum_z[SumW-1:CoordW-1] == 3'b111) begin
      sat_z = sum_z[CoordW-1:0];
    end else begin
      sat_z = sum_z[SumW-1] ? SatMin : SatMax;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and ready
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && have_prev) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_ABS;
      ST_ABS:  state_next = ST_NORM;
      ST_NORM: begin
        if (norm_zero) begin
          state_next = ST_EMIT;
        end else if (!norm_right && !norm_left) begin
          state_next = ST_SQR;
        end
      end
      ST_SQR: begin
        if (step == 2'd3) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_bit[0]) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == 5'(QuotW - 1)) begin
          state_next = sel ? ST_EMIT : ST_MUL;
        end
      end
      ST_EMIT: begin
        if (emit_load && emit_k == 2'd3) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ribbon_width <= WidthReset;
    end else if (cfg_write_en) begin
      ribbon_width <= cfg_write_data;
    end
  end

  // held point: store a first point at once, advance after the last corner
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_z    <= '0;
    end else if (in_take && !have_prev) begin
      prev_x    <= point_x;
      prev_y    <= point_y;
      prev_z    <= point_z;
      have_prev <= !end_of_line;
    end else if (emit_load && emit_k == 2'd3) begin
      prev_x    <= cur_x;
      prev_y    <= cur_y;
      prev_z    <= cur_z;
      have_prev <= !cur_eol;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur_x   <= point_x;
        cur_y   <= point_y;
        cur_z   <= point_z;
        cur_eol <= end_of_line;
      end
      ST_DIFF: begin
        ax <= {cur_x[CoordW-1], cur_x} - {prev_x[CoordW-1], prev_x};
        ay <= {cur_y[CoordW-1], cur_y} - {prev_y[CoordW-1], prev_y};
        az <= {cur_z[CoordW-1], cur_z} - {prev_z[CoordW-1], prev_z};
      end
      ST_ABS: begin
        dx_neg <= ax[DiffW-1];
        dz_pos <= !az[DiffW-1] && (az != '0);
        ax     <= ax[DiffW-1] ? '0 - ax : ax;
        ay     <= ay[DiffW-1] ? '0 - ay : ay;
        az     <= az[DiffW-1] ? '0 - az : az;
      end
      ST_NORM: begin
        step <= 2'd0;
        if (norm_zero) begin
          mx     <= '0;
          mz     <= '0;
          emit_k <= 2'd0;
        end else if (norm_right) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
          az <= az >> 1;
        end else if (norm_left) begin
          ax <= ax << 1;
          ay <= ay << 1;
          az <= az << 1;
        end
      end
      ST_SQR: begin
        // square into prod_q, summed into acc on the next step
        prod_q <= mul_p;
        step   <= step + 2'd1;
        if (step == 2'd0) begin
          acc <= '0;
        end else begin
          acc <= acc + prod_q;
        end
        root     <= '0;
        root_bit <= RootBitTop;
      end
      ST_ROOT: begin
        if (root_ge) begin
          acc  <= acc - root_try;
          root <= (root >> 1) + root_bit;
        end else begin
          root <= root >> 1;
        end
        root_bit <= root_bit >> 2;
        sel      <= 1'b0;
      end
      ST_MUL: begin
        prod_q <= mul_p;
      end
      ST_PREP: begin
        num     <= NumW'(prod_q[DenW-1:0]) + NumW'(root[31:0]);
        den     <= {root[31:0], 24'd0};
        quot    <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        if (div_ge) begin
          num <= num - {1'b0, den};
        end
        den     <= den >> 1;
        quot    <= quot_next;
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'(QuotW - 1)) begin
          if (sel) begin
            mz <= quot_next;
          end else begin
            mx <= quot_next;
          end
          sel    <= 1'b1;
          emit_k <= 2'd0;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          emit_k <= emit_k + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: hold a corner until taken, reload as the next one comes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      corner_x     <= sat_x;
      corner_y     <= base_y;
      corner_z     <= sat_z;
      corner_index <= emit_k;
      quad_done    <= (emit_k == 2'd3);
    end
  end

endmodule
